/* hdl/wsfr_pkg.sv */
// Shared types and constants for the WebSocket frame receiver.
// No dependencies; imported by wsfr_parser and the top level.
`default_nettype none

package wsfr_pkg;

    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_HDR0    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR1    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXTLEN  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_MASK    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CLOSED  = 3'd5;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [63:0] PING_MAX = 64'd125;

    localparam logic [2:0] EV_DATA     = 3'd0;
    localparam logic [2:0] EV_MSG_END  = 3'd1;
    localparam logic [2:0] EV_PING     = 3'd2;
    localparam logic [2:0] EV_PING_NIL = 3'd3;
    localparam logic [2:0] EV_CLOSE    = 3'd4;
    localparam logic [2:0] EV_DROPPED  = 3'd5;
    localparam logic [2:0] EV_UNKNOWN  = 3'd6;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] payload_byte;
        logic       binary_message;
        logic       last;
    } wsfr_result_t;

endpackage

`default_nettype wire

/* hdl/wsfr_parser.sv */
// Frame parser: header, length and mask decode, unmasking and event selection.
// Holds all parse state; produces at most one result per accepted byte.
// Depends on wsfr_pkg.
`default_nettype none

module wsfr_parser (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   byte_valid,
    input  wire [7:0]             stream_byte,
    output logic                  res_valid,
    output wsfr_pkg::wsfr_result_t res
);
    import wsfr_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  kind_reg, kind_next;
    logic        final_reg, final_next;
    logic        masked_reg, masked_next;
    logic [63:0] rem_reg, rem_next;
    logic [31:0] mask_reg, mask_next;
    logic [1:0]  pos_reg, pos_next;
    logic        frag_reg, frag_next;
    logic        binary_reg, binary_next;
    logic        has_reg, has_next;

    logic        len_done;
    logic        hdr_done;
    logic        fend;
    logic        have;
    logic [7:0]  ub;
    logic [7:0]  key_byte;
    logic        is_data;
    logic        dropped;

    always_comb begin
        case (pos_reg)
            2'd0:    key_byte = mask_reg[31:24];
            2'd1:    key_byte = mask_reg[23:16];
            2'd2:    key_byte = mask_reg[15:8];
            default: key_byte = mask_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        final_next  = final_reg;
        masked_next = masked_reg;
        rem_next    = rem_reg;
        mask_next   = mask_reg;
        pos_next    = pos_reg;
        frag_next   = frag_reg;
        binary_next = binary_reg;
        has_next    = has_reg;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        fend        = 1'b0;
        have        = 1'b0;
        ub          = stream_byte;
        res_valid   = 1'b0;
        res         = '0;
        is_data     = 1'b0;
        dropped     = 1'b0;

        if (byte_valid) begin
            unique case (phase_reg)
                PH_HDR0: begin
                    kind_next  = stream_byte[3:0];
                    final_next = stream_byte[7];
                    phase_next = PH_HDR1;
                end
                PH_HDR1: begin
                    masked_next = stream_byte[7];
                    if (stream_byte[6:0] == LEN_EXT16 || stream_byte[6:0] == LEN_EXT64) begin
                        cnt_next   = (stream_byte[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                        rem_next   = '0;
                        phase_next = PH_EXTLEN;
                    end else begin
                        rem_next = {57'd0, stream_byte[6:0]};
                        len_done = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    rem_next = {rem_reg[55:0], stream_byte};
                    cnt_next = cnt_reg - 4'd1;
                    len_done = (cnt_next == 4'd0);
                end
                PH_MASK: begin
                    mask_next = {mask_reg[23:0], stream_byte};
                    cnt_next  = cnt_reg - 4'd1;
                    hdr_done  = (cnt_next == 4'd0);
                end
                PH_PAYLOAD: begin
                    if (masked_reg) begin
                        ub = stream_byte ^ key_byte;
                    end
                    pos_next = pos_reg + 2'd1;
                    rem_next = rem_reg - 64'd1;
                    if (rem_next == 64'd0) begin
                        fend = 1'b1;
                        have = 1'b1;
                    end else if (kind_reg == OP_CONT || kind_reg == OP_TEXT
                                 || kind_reg == OP_BIN) begin
                        if (!(kind_reg != OP_CONT && frag_reg)) begin
                            has_next  = 1'b1;
                            res_valid = 1'b1;
                            res = '{EV_DATA, ub, binary_reg, 1'b0};
                        end
                    end else if (kind_reg == OP_PING) begin
                        res_valid = 1'b1;
                        res = '{EV_PING, ub, 1'b0, 1'b0};
                    end
                end
                default: begin
                end
            endcase

            if (len_done) begin
                mask_next = '0;
                if (masked_next) begin
                    cnt_next   = 4'd4;
                    phase_next = PH_MASK;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done) begin
                if ((kind_next == OP_TEXT || kind_next == OP_BIN) && !frag_reg) begin
                    binary_next = (kind_next == OP_BIN);
                    has_next    = 1'b0;
                end
                if (kind_next == OP_PING && rem_next > PING_MAX) begin
                    kind_next = OP_PONG;
                end
                pos_next = '0;
                if (rem_next == 64'd0) begin
                    fend = 1'b1;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end

            if (fend) begin
                phase_next = PH_HDR0;
                is_data = (kind_next == OP_CONT || kind_next == OP_TEXT
                           || kind_next == OP_BIN);
                dropped = (kind_next != OP_CONT) && frag_reg;
                if (is_data) begin
                    if (dropped) begin
                        res_valid = 1'b1;
                        res = '{EV_DROPPED, 8'd0, 1'b0, 1'b0};
                    end else if (final_next) begin
                        frag_next = 1'b0;
                        has_next  = 1'b0;
                        if (have) begin
                            res_valid = 1'b1;
                            res = '{EV_DATA, ub, binary_next, 1'b1};
                        end else if (has_next == 1'b0 && has_reg && !hdr_done) begin
                            res_valid = 1'b1;
                            res = '{EV_MSG_END, 8'd0, binary_next, 1'b1};
                        end else if (hdr_done && !((kind_next == OP_TEXT
                                     || kind_next == OP_BIN) && !frag_reg) && has_reg) begin
                            res_valid = 1'b1;
                            res = '{EV_MSG_END, 8'd0, binary_next, 1'b1};
                        end
                    end else begin
                        if (kind_next != OP_CONT) begin
                            frag_next = 1'b1;
                        end
                        if (have) begin
                            has_next  = 1'b1;
                            res_valid = 1'b1;
                            res = '{EV_DATA, ub, binary_next, 1'b0};
                        end
                    end
                end else begin
                    case (kind_next)
                        OP_PING: begin
                            res_valid = 1'b1;
                            if (have) begin
                                res = '{EV_PING, ub, 1'b0, 1'b1};
                            end else begin
                                res = '{EV_PING_NIL, 8'd0, 1'b0, 1'b1};
                            end
                        end
                        OP_CLOSE: begin
                            phase_next = PH_CLOSED;
                            res_valid  = 1'b1;
                            res = '{EV_CLOSE, 8'd0, 1'b0, 1'b0};
                        end
                        OP_PONG: begin
                        end
                        default: begin
                            res_valid = 1'b1;
                            res = '{EV_UNKNOWN, 8'd0, 1'b0, 1'b0};
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            cnt_reg    <= '0;
            kind_reg   <= '0;
            final_reg  <= 1'b0;
            masked_reg <= 1'b0;
            rem_reg    <= '0;
            mask_reg   <= '0;
            pos_reg    <= '0;
            frag_reg   <= 1'b0;
            binary_reg <= 1'b0;
            has_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            kind_reg   <= kind_next;
            final_reg  <= final_next;
            masked_reg <= masked_next;
            rem_reg    <= rem_next;
            mask_reg   <= mask_next;
            pos_reg    <= pos_next;
            frag_reg   <= frag_next;
            binary_reg <= binary_next;
            has_reg    <= has_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/websocket_frame_receiver_core.sv */
// Top level of the WebSocket frame receiver: stream ports and result register.
// Depends on wsfr_pkg and wsfr_parser.
//
//  channel | direction | request                | contents
//  s_      | in        | one received byte      | tdata[7:0] stream_byte
//  m_      | out       | one event              | tdata payload, tuser event and binary,
//          |           |                        | tlast end of message or ping payload
//
// One byte is accepted every cycle that the result register is empty or
// is being taken. The result is registered and appears in the cycle after
// its byte. A stall on m_ holds the result and stops s_ until it is taken.
// Reset returns the parser to the first header byte and clears any close.
`default_nettype none

module websocket_frame_receiver_core (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,   // [7:0] stream_byte
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic [3:0] m_tuser,   // [2:0] event_res, [3] binary_message
    output logic       m_tlast
);
    import wsfr_pkg::*;

    logic         accept;
    logic         res_valid;
    wsfr_result_t res;
    logic         m_valid_reg;
    wsfr_result_t m_res_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    wsfr_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_valid  (accept),
        .stream_byte (s_tdata),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= accept && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.payload_byte;
    assign m_tuser  = {m_res_reg.binary_message, m_res_reg.event_res};
    assign m_tlast  = m_res_reg.last;

endmodule

`default_nettype wire

/* dv/websocket_frame_receiver_core_tb.sv */
// Self-checking testbench for websocket_frame_receiver_core: directed and random frame streams.
// Expected events come from a behavioral parser inside this file; uses wsfr_pkg.
`default_nettype none

module websocket_frame_receiver_core_tb;

    import wsfr_pkg::*;

    localparam int          RANDOM_BYTES = 1400;
    localparam int          DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int          STALL_HOLD   = 300;

    localparam logic [3:0] OP_RSV_LO      = 4'h3;
    localparam logic [3:0] OP_RSV_HI      = 4'h7;
    localparam logic [3:0] OP_RSV_CTRL_LO = 4'hB;
    localparam logic [3:0] OP_RSV_CTRL_HI = 4'hF;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;

    websocket_frame_receiver_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial forever #5 aclk = ~aclk;

    // parser state, mirrors the block after reset
    logic [2:0]  phase_q      = PH_HDR0;
    logic [3:0]  hdr_left     = 4'd0;
    logic [3:0]  kind_q       = OP_CONT;
    logic        fin_q        = 1'b0;
    logic        masked_q     = 1'b0;
    logic [63:0] remain_q     = 64'd0;
    logic [31:0] mask_q       = 32'd0;
    logic [1:0]  mask_idx     = 2'd0;
    logic        frag_open    = 1'b0;
    logic        msg_binary   = 1'b0;
    logic        msg_nonempty = 1'b0;

    wsfr_result_t pending_events[$];
    int           mismatch_count = 0;
    int unsigned  bytes_sent     = 0;
    bit           no_idle        = 1'b0;
    int           rx_hold_req    = 0;

    function automatic void push_event(logic [2:0] ev, logic [7:0] b, logic bin, logic lst);
        wsfr_result_t r;
        r.event_res      = ev;
        r.payload_byte   = b;
        r.binary_message = bin;
        r.last           = lst;
        pending_events = {pending_events, r};
    endfunction

    function automatic logic is_data_frame();
        return kind_q == OP_CONT || kind_q == OP_TEXT || kind_q == OP_BIN;
    endfunction

    function automatic logic frame_is_dropped();
        return kind_q != OP_CONT && frag_open;
    endfunction

    function automatic void finish_frame(logic have, logic [7:0] b);
        phase_q = PH_HDR0;
        if (is_data_frame()) begin
            if (frame_is_dropped()) begin
                push_event(EV_DROPPED, 8'h00, 1'b0, 1'b0);
            end else if (fin_q) begin
                if (have)
                    push_event(EV_DATA, b, msg_binary, 1'b1);
                else if (msg_nonempty)
                    push_event(EV_MSG_END, 8'h00, msg_binary, 1'b1);
                frag_open    = 1'b0;
                msg_nonempty = 1'b0;
            end else begin
                if (kind_q != OP_CONT)
                    frag_open = 1'b1;
                if (have) begin
                    msg_nonempty = 1'b1;
                    push_event(EV_DATA, b, msg_binary, 1'b0);
                end
            end
        end else begin
            case (kind_q)
                OP_PING: begin
                    if (have)
                        push_event(EV_PING, b, 1'b0, 1'b1);
                    else
                        push_event(EV_PING_NIL, 8'h00, 1'b0, 1'b1);
                end
                OP_CLOSE: begin
                    phase_q = PH_CLOSED;
                    push_event(EV_CLOSE, 8'h00, 1'b0, 1'b0);
                end
                OP_PONG: begin
                end
                default: begin
                    push_event(EV_UNKNOWN, 8'h00, 1'b0, 1'b0);
                end
            endcase
        end
    endfunction

    function automatic void end_of_header();
        if ((kind_q == OP_TEXT || kind_q == OP_BIN) && !frag_open) begin
            msg_binary   = (kind_q == OP_BIN);
            msg_nonempty = 1'b0;
        end
        // demote an oversized ping so its payload is skipped
        if (kind_q == OP_PING && remain_q > PING_MAX)
            kind_q = OP_PONG;
        mask_idx = 2'd0;
        if (remain_q == 64'd0)
            finish_frame(1'b0, 8'h00);
        else
            phase_q = PH_PAYLOAD;
    endfunction

    function automatic void end_of_length();
        mask_q = 32'd0;
        if (masked_q) begin
            hdr_left = 4'd4;
            phase_q  = PH_MASK;
        end else begin
            end_of_header();
        end
    endfunction

    function automatic void parse_stream_byte(logic [7:0] b);
        logic [7:0] d;
        logic [6:0] len;
        case (phase_q)
            PH_HDR0: begin
                kind_q  = b[3:0];
                fin_q   = b[7];
                phase_q = PH_HDR1;
            end
            PH_HDR1: begin
                masked_q = b[7];
                len      = b[6:0];
                if (len == LEN_EXT16 || len == LEN_EXT64) begin
                    hdr_left = (len == LEN_EXT16) ? 4'd2 : 4'd8;
                    remain_q = 64'd0;
                    phase_q  = PH_EXTLEN;
                end else begin
                    remain_q = 64'(len);
                    end_of_length();
                end
            end
            PH_EXTLEN: begin
                remain_q = {remain_q[55:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                    end_of_length();
            end
            PH_MASK: begin
                mask_q   = {mask_q[23:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                    end_of_header();
            end
            PH_PAYLOAD: begin
                d = b;
                if (masked_q)
                    d = b ^ mask_q[31 - 8 * mask_idx -: 8];
                mask_idx = mask_idx + 2'd1;
                remain_q = remain_q - 64'd1;
                if (remain_q == 64'd0) begin
                    finish_frame(1'b1, d);
                end else if (is_data_frame()) begin
                    if (!frame_is_dropped()) begin
                        msg_nonempty = 1'b1;
                        push_event(EV_DATA, d, msg_binary, 1'b0);
                    end
                end else if (kind_q == OP_PING) begin
                    push_event(EV_PING, d, 1'b0, 1'b0);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        parse_stream_byte(b);
    endtask

    // form: 0 seven-bit length, 1 sixteen-bit, 2 sixty-four-bit
    task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                              input int unsigned len, input int form);
        logic [63:0] len64;
        len64 = 64'(len);
        if (form == 0 && len > 125)
            form = 1;
        if (form == 1 && len > 65535)
            form = 2;
        send_byte({fin, 3'($urandom), op});
        if (form == 0) begin
            send_byte({masked, 7'(len)});
        end else if (form == 1) begin
            send_byte({masked, LEN_EXT16});
            send_byte(len64[15:8]);
            send_byte(len64[7:0]);
        end else begin
            send_byte({masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--)
                send_byte(len64[8 * i +: 8]);
        end
        if (masked)
            repeat (4) send_byte(8'($urandom));
        repeat (len) send_byte(8'($urandom));
    endtask

    function automatic int unsigned random_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 8);
        if (r < 95)
            return $urandom_range(9, 125);
        return $urandom_range(126, 300);
    endfunction

    function automatic int random_form();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 0;
        if (r < 93)
            return 1;
        return 2;
    endfunction

    task automatic send_side_frame();
        int          pick;
        int unsigned len;
        logic [3:0]  op;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(125, 140) : $urandom_range(0, 20);
            send_frame(1'($urandom), OP_PING, 1'($urandom), len, random_form());
        end else if (pick == 4) begin
            send_frame(1'($urandom), OP_PONG, 1'($urandom), random_len(), random_form());
        end else if (pick < 7) begin
            if ($urandom_range(0, 1) == 0)
                op = 4'($urandom_range(OP_RSV_LO, OP_RSV_HI));
            else
                op = 4'($urandom_range(OP_RSV_CTRL_LO, OP_RSV_CTRL_HI));
            send_frame(1'($urandom), op, 1'($urandom), random_len(), random_form());
        end else begin
            op = $urandom_range(0, 1) ? OP_BIN : OP_TEXT;
            send_frame(1'($urandom), op, 1'($urandom), random_len(), random_form());
        end
    endtask

    task automatic send_message();
        int         n_cont;
        logic [3:0] op;
        n_cont = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        case ($urandom_range(0, 9))
            0:          op = OP_CONT;
            1, 2, 3, 4: op = OP_TEXT;
            default:    op = OP_BIN;
        endcase
        send_frame(n_cont == 0, op, 1'($urandom), random_len(), random_form());
        for (int i = 1; i <= n_cont; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_side_frame();
            send_frame(i == n_cont, OP_CONT, 1'($urandom), random_len(), random_form());
        end
    endtask

    // random bytes; keep out close frames and long extended lengths, then resync
    task automatic send_noise();
        int         n;
        logic [7:0] b;
        n = $urandom_range(1, 12);
        while (n > 0 || phase_q != PH_HDR0) begin
            b = 8'($urandom);
            if (phase_q == PH_HDR0 && b[3:0] == OP_CLOSE)
                b[3:0] = OP_PING;
            if (phase_q == PH_EXTLEN && hdr_left > 4'd1)
                b = 8'h00;
            send_byte(b);
            if (n > 0)
                n--;
        end
    endtask

    task automatic test_extreme_bytes();
        repeat (2) send_byte(8'hFF);
        repeat (8) send_byte(8'h00);
        repeat (4) send_byte(8'hFF);
        repeat (2) send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h82);
        send_byte(8'h81);
        repeat (4) send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    task automatic test_length_forms();
        send_frame(1'b1, OP_TEXT, 1'b0, 0, 0);
        send_frame(1'b1, OP_TEXT, 1'b0, 3, 0);
        send_frame(1'b1, OP_BIN, 1'b1, 4, 1);
        send_frame(1'b1, OP_BIN, 1'b1, 2, 2);
        send_frame(1'b1, OP_TEXT, 1'b0, 0, 2);
    endtask

    task automatic test_fragmented_messages();
        send_frame(1'b0, OP_TEXT, 1'b0, 2, 0);
        send_frame(1'b1, OP_PING, 1'b1, 1, 0);
        send_frame(1'b0, OP_BIN, 1'b0, 1, 0);
        send_frame(1'b0, OP_CONT, 1'b1, 0, 0);
        send_frame(1'b1, OP_CONT, 1'b0, 0, 0);
        send_frame(1'b0, OP_BIN, 1'b0, 0, 0);
        send_frame(1'b1, OP_CONT, 1'b0, 0, 0);
        send_frame(1'b1, OP_CONT, 1'b0, 2, 0);
        send_frame(1'b0, OP_TEXT, 1'b1, 1, 0);
        send_frame(1'b1, OP_TEXT, 1'b0, 0, 0);
        send_frame(1'b1, OP_CONT, 1'b0, 1, 0);
    endtask

    task automatic test_control_frames();
        send_frame(1'b1, OP_PING, 1'b0, 0, 0);
        send_frame(1'b0, OP_PING, 1'b1, 3, 1);
        send_frame(1'b1, OP_PONG, 1'b1, 3, 0);
        send_frame(1'b1, OP_RSV_LO, 1'b0, 1, 0);
        send_frame(1'b1, OP_RSV_CTRL_LO, 1'b0, 0, 0);
        send_frame(1'b1, OP_PING, 1'b0, 126, 0);
    endtask

    task automatic test_random_traffic();
        int unsigned first;
        int          pick;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES) begin
            no_idle = ($urandom_range(0, 5) == 0);
            pick    = $urandom_range(0, 19);
            if (pick == 0)
                send_noise();
            else if (pick < 4)
                send_side_frame();
            else
                send_message();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        no_idle     = 1'b1;
        rx_hold_req = STALL_HOLD;
        repeat (4) send_frame(1'b1, OP_BIN, 1'($urandom), 30, 0);
        no_idle = 1'b0;
    endtask

    task automatic test_close_frame();
        send_frame(1'b0, OP_CLOSE, 1'b1, 3, 0);
        repeat (12) send_byte(8'($urandom));
    endtask

    initial begin : rx_pacer
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end else if (stall == 0 && $urandom_range(0, 2) == 0) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void log_mismatch(string what, wsfr_result_t got, wsfr_result_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: got ev/byte/bin/last %0d/%02h/%0b/%0b, expected %0d/%02h/%0b/%0b",
                     what, got.event_res, got.payload_byte, got.binary_message, got.last,
                     want.event_res, want.payload_byte, want.binary_message, want.last);
    endfunction

    always @(posedge aclk) begin : result_check
        wsfr_result_t got;
        wsfr_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.event_res      = m_tuser[2:0];
            got.payload_byte   = m_tdata;
            got.binary_message = m_tuser[3];
            got.last           = m_tlast;
            if (pending_events.size() == 0) begin
                log_mismatch("unexpected event", got, '0);
            end else begin
                want = pending_events.pop_front();
                if (got !== want)
                    log_mismatch("event mismatch", got, want);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("websocket_frame_receiver_core regression: fail");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_extreme_bytes();
        test_length_forms();
        test_fragmented_messages();
        test_control_frames();
        test_random_traffic();
        test_output_stall();
        test_close_frame();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("websocket_frame_receiver_core regression: pass");
        else
            $display("websocket_frame_receiver_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
